// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the page cache.
// The enclosing module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define LPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/lpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Opcodes, result kinds and sequencer states of the LRU page cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int BYTE_W = 8;
	localparam int DATA_W = 16;

	typedef enum logic [1:0] {
		OP_RD_BYTE = 2'd0,
		OP_RD_HALF = 2'd1,
		OP_WR_BYTE = 2'd2,
		OP_FILL    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_FETCH  = 2'd1,
		KIND_WRITE  = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_RDREQ,
		S_RDLO,
		S_RDHI,
		S_EMIT
	} state_t;

endpackage

// ===== hw/rtl/lpc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_req_if
// Request channel of the page cache: opcode, address and data byte.
// ----------------------------------------------------------------------------
interface lpc_req_if #(
	parameter int AW = 23
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [AW-1:0]             address;
	logic [lpc_pkg::BYTE_W-1:0] data_in;

	modport source (output valid, opcode, address, data_in, input ready);
	modport sink (input valid, opcode, address, data_in, output ready);
endinterface

// ===== hw/rtl/lpc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_rsp_if
// Result channel of the page cache: kind, memory address, data and slot.
// ----------------------------------------------------------------------------
interface lpc_rsp_if #(
	parameter int AW = 23,
	parameter int SW = 4
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [AW-1:0]             mem_address;
	logic [lpc_pkg::DATA_W-1:0] data_out;
	logic                      was_hit;
	logic [SW-1:0]             slot;

	modport source (output valid, kind, mem_address, data_out, was_hit, slot, input ready);
	modport sink (input valid, kind, mem_address, data_out, was_hit, slot, output ready);
endinterface

// ===== hw/rtl/lru_page_cache_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_controller
// Fully associative write-through page cache with true LRU replacement.
//
//   channel | dir | word
//   req     | in  | opcode, address, data_in
//   rsp     | out | kind, mem_address, data_out, was_hit, slot
//
// A word is taken, then its tag is compared. For reads and the last fill byte,
// page memory then reads through its single read port, one byte for a byte read
// and two for a halfword that does not start at the last byte of the page; then
// the output is loaded. Writes, fetches and rejections go from the compare to
// the output. Fill bytes that give no result return to idle after the compare.
// Reset clears only control state; no clearing pass is needed.
// A new word is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_cache_controller #(
	parameter int PAGE_BYTES   = 256,
	parameter int SLOT_COUNT   = 16,
	parameter int ADDRESS_BITS = 23
) (
	input logic       clk,
	input logic       arst_n,
	lpc_req_if.sink   req,
	lpc_rsp_if.source rsp
);

	localparam int OFS_W  = $clog2(PAGE_BYTES);
	localparam int SW     = $clog2(SLOT_COUNT);
	localparam int TAG_W  = ADDRESS_BITS - OFS_W;
	localparam int MEM_AW = SW + OFS_W;
	localparam int DEPTH  = SLOT_COUNT * PAGE_BYTES;
	localparam int BW     = lpc_pkg::BYTE_W;

	lpc_pkg::state_t state_q, state_d;

	logic [1:0]              op_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [BW-1:0]           din_q;

	logic [TAG_W-1:0] tag_q  [SLOT_COUNT];
	logic [SW-1:0]    rank_q [SLOT_COUNT];
	logic [SW:0]      used_q;
	logic             fill_pend_q;
	logic [OFS_W-1:0] fill_cnt_q;
	logic [SW-1:0]    fill_slot_q;
	logic [OFS_W-1:0] pend_ofs_q;
	logic             pend_half_q;

	logic [BW-1:0] mem [DEPTH];
	logic [BW-1:0] rdata_q;

	logic [SW-1:0]    rd_slot_q;
	logic [OFS_W-1:0] rd_ofs_q;
	logic             rd_half_q;

	logic [1:0]              res_kind_q;
	logic [ADDRESS_BITS-1:0] res_addr_q;
	logic [BW-1:0]           res_lo_q;
	logic [BW-1:0]           res_hi_q;
	logic                    res_hit_q;
	logic [SW-1:0]           res_slot_q;

	logic                    out_vld_q;
	logic [1:0]              out_kind_q;
	logic [ADDRESS_BITS-1:0] out_addr_q;
	logic [2*BW-1:0]         out_data_q;
	logic                    out_hit_q;
	logic [SW-1:0]           out_slot_q;

	logic [TAG_W-1:0]  tag_in;
	logic [OFS_W-1:0]  ofs_in;
	logic [SLOT_COUNT-1:0] match;
	logic              hit;
	logic [SW-1:0]     hit_slot;
	logic              full;
	logic [SW-1:0]     victim;
	logic [SW-1:0]     alloc_slot;
	logic [SW-1:0]     touch_slot;
	logic [SW:0]       touch_rank;
	logic              is_fill;
	logic              is_write;
	logic              fill_last;
	logic              look_fill;
	logic              look_reject;
	logic              look_write;
	logic              look_rd_hit;
	logic              look_rd_miss;
	logic              out_free;
	logic              load_out;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [MEM_AW-1:0] mem_raddr;

	assign tag_in   = addr_q[ADDRESS_BITS-1:OFS_W];
	assign ofs_in   = addr_q[OFS_W-1:0];
	assign is_fill  = (op_q == lpc_pkg::OP_FILL);
	assign is_write = (op_q == lpc_pkg::OP_WR_BYTE);
	assign fill_last = (fill_cnt_q == OFS_W'(PAGE_BYTES - 1));
	assign full     = (used_q == (SW+1)'(SLOT_COUNT));
	assign out_free = !out_vld_q || rsp.ready;

	always_comb begin
		hit_slot = '0;
		victim   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i] = ((SW+1)'(i) < used_q) && (tag_q[i] == tag_in);
		end
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_slot = SW'(i);
			end
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (rank_q[i] == SW'(SLOT_COUNT - 1)) begin
				victim = SW'(i);
			end
		end
		hit        = |match;
		alloc_slot = full ? victim : used_q[SW-1:0];
		touch_slot = hit ? hit_slot : alloc_slot;
		touch_rank = (hit || full) ? {1'b0, rank_q[touch_slot]} : used_q;
	end

	always_comb begin
		look_fill    = (state_q == lpc_pkg::S_LOOK) && is_fill && fill_pend_q;
		look_reject  = (state_q == lpc_pkg::S_LOOK) && (is_fill != fill_pend_q);
		look_write   = (state_q == lpc_pkg::S_LOOK) && is_write && !fill_pend_q;
		look_rd_hit  = (state_q == lpc_pkg::S_LOOK) && !is_fill && !is_write
		               && !fill_pend_q && hit;
		look_rd_miss = (state_q == lpc_pkg::S_LOOK) && !is_fill && !is_write
		               && !fill_pend_q && !hit;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpc_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = lpc_pkg::S_LOOK;
				end
			end
			lpc_pkg::S_LOOK: begin
				if (look_fill) begin
					state_d = fill_last ? lpc_pkg::S_RDREQ : lpc_pkg::S_IDLE;
				end else if (look_rd_hit) begin
					state_d = lpc_pkg::S_RDREQ;
				end else begin
					state_d = lpc_pkg::S_EMIT;
				end
			end
			lpc_pkg::S_RDREQ: begin
				state_d = lpc_pkg::S_RDLO;
			end
			lpc_pkg::S_RDLO: begin
				if (rd_half_q && (rd_ofs_q != '1)) begin
					state_d = lpc_pkg::S_RDHI;
				end else begin
					state_d = lpc_pkg::S_EMIT;
				end
			end
			lpc_pkg::S_RDHI: begin
				state_d = lpc_pkg::S_EMIT;
			end
			lpc_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = lpc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = (state_q == lpc_pkg::S_IDLE);
		load_out  = (state_q == lpc_pkg::S_EMIT) && out_free;
		mem_we    = look_fill || (look_write && hit);
		mem_waddr = is_fill ? {fill_slot_q, fill_cnt_q} : {hit_slot, ofs_in};
		if (state_q == lpc_pkg::S_RDREQ) begin
			mem_raddr = {rd_slot_q, rd_ofs_q};
		end else begin
			mem_raddr = {rd_slot_q, rd_ofs_q + OFS_W'(1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpc_pkg::S_IDLE;
			used_q      <= '0;
			fill_pend_q <= 1'b0;
			fill_cnt_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (look_fill) begin
				fill_cnt_q <= fill_cnt_q + OFS_W'(1);
				if (fill_last) begin
					fill_pend_q <= 1'b0;
				end
			end
			if (look_rd_miss) begin
				fill_pend_q <= 1'b1;
				fill_cnt_q  <= '0;
				if (!full) begin
					used_q <= used_q + (SW+1)'(1);
				end
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.opcode;
			addr_q <= req.address;
			din_q  <= req.data_in;
		end
		if (look_rd_hit || look_rd_miss) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (SW'(i) == touch_slot) begin
					rank_q[i] <= '0;
				end else if (((SW+1)'(i) < used_q) && ({1'b0, rank_q[i]} < touch_rank)) begin
					rank_q[i] <= rank_q[i] + SW'(1);
				end
			end
		end
		if (look_rd_miss) begin
			tag_q[alloc_slot] <= tag_in;
			fill_slot_q       <= alloc_slot;
			pend_ofs_q        <= ofs_in;
			pend_half_q       <= op_q[0];
		end
		if (look_reject) begin
			res_kind_q <= lpc_pkg::KIND_REJECT;
			res_addr_q <= '0;
			res_lo_q   <= '0;
			res_hi_q   <= '0;
			res_hit_q  <= 1'b0;
			res_slot_q <= '0;
		end
		if (look_write) begin
			res_kind_q <= lpc_pkg::KIND_WRITE;
			res_addr_q <= addr_q;
			res_lo_q   <= din_q;
			res_hi_q   <= '0;
			res_hit_q  <= hit;
			res_slot_q <= hit ? hit_slot : '0;
		end
		if (look_rd_miss) begin
			res_kind_q <= lpc_pkg::KIND_FETCH;
			res_addr_q <= {tag_in, OFS_W'(0)};
			res_lo_q   <= '0;
			res_hi_q   <= '0;
			res_hit_q  <= 1'b0;
			res_slot_q <= alloc_slot;
		end
		if (look_rd_hit) begin
			rd_slot_q  <= hit_slot;
			rd_ofs_q   <= ofs_in;
			rd_half_q  <= op_q[0];
			res_kind_q <= lpc_pkg::KIND_DATA;
			res_addr_q <= addr_q;
			res_hit_q  <= 1'b1;
			res_slot_q <= hit_slot;
		end
		if (look_fill && fill_last) begin
			rd_slot_q  <= fill_slot_q;
			rd_ofs_q   <= pend_ofs_q;
			rd_half_q  <= pend_half_q;
			res_kind_q <= lpc_pkg::KIND_DATA;
			res_addr_q <= {tag_q[fill_slot_q], pend_ofs_q};
			res_hit_q  <= 1'b0;
			res_slot_q <= fill_slot_q;
		end
		if (state_q == lpc_pkg::S_RDLO) begin
			res_lo_q <= rdata_q;
			res_hi_q <= '0;
		end
		if (state_q == lpc_pkg::S_RDHI) begin
			res_hi_q <= rdata_q;
		end
		if (load_out) begin
			out_kind_q <= res_kind_q;
			out_addr_q <= res_addr_q;
			out_data_q <= {res_hi_q, res_lo_q};
			out_hit_q  <= res_hit_q;
			out_slot_q <= res_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= din_q;
		end
		rdata_q <= mem[mem_raddr];
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.mem_address = out_addr_q;
	assign rsp.data_out    = out_data_q;
	assign rsp.was_hit     = out_hit_q;
	assign rsp.slot        = out_slot_q;

	`LPC_ASSERT_IMP(a_cnt_needs_pend, fill_cnt_q != '0, fill_pend_q)
	`LPC_ASSERT_IMP(a_used_bound, state_q == lpc_pkg::S_LOOK, used_q <= (SW+1)'(SLOT_COUNT))
	`LPC_ASSERT_IMP(a_pend_has_slot, fill_pend_q, used_q != '0)
	`LPC_ASSERT_NXT(a_emit_loads, load_out, out_vld_q)

endmodule

// ===== tb/lpc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_tb_pkg
// Word type used by the checker of the page cache bench.
// ----------------------------------------------------------------------------
package lpc_tb_pkg;

	import lpc_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [22:0] mem_address;
		logic [15:0] data_out;
		logic        was_hit;
		logic [3:0]  slot;
	} cache_result_t;

endpackage

// ===== tb/lpc_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_tb_if
// The bench uses the block's own channel interfaces; this file holds a small
// monitor of words in flight and failures, shared by top and checker.
// ----------------------------------------------------------------------------
interface lpc_tb_if;
	int unsigned outstanding;
	int unsigned failures;

	modport source (output outstanding, failures);
	modport sink (input outstanding, failures);
endinterface

// ===== tb/lpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Watches both channels, predicts any result of each accepted request word
// with its own model of the LRU page cache and compares each result word.
// ----------------------------------------------------------------------------
module lpc_checker
	import lpc_pkg::*;
	import lpc_tb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	lpc_req_if      req,
	lpc_rsp_if      rsp,
	lpc_tb_if.source mon
);

	localparam int PAGE = 256;
	localparam int SLOTS = 16;

	logic [14:0] tag_of [SLOTS];
	logic [3:0]  newer_of [SLOTS];
	logic [3:0]  older_of [SLOTS];
	logic [7:0]  page_mem [SLOTS*PAGE];
	int unsigned used;
	logic [3:0]  mru, lru;
	bit          filling;
	int unsigned fill_idx;
	logic [7:0]  want_ofs;
	bit          want_half;

	cache_result_t expected_results [$];
	int unsigned mismatches;

	function automatic void promote(input logic [3:0] s);
		logic [3:0] p, n;
		if (s == mru) begin
			return;
		end
		p = older_of[s];
		if (s == lru) begin
			newer_of[p] = p;
			lru = p;
		end else begin
			n = newer_of[s];
			newer_of[p] = n;
			older_of[n] = p;
		end
		older_of[s] = s;
		newer_of[s] = mru;
		older_of[mru] = s;
		mru = s;
	endfunction

	function automatic logic [15:0] fetch_value(input logic [3:0] s, input logic [7:0] o,
			input bit half);
		logic [15:0] v;
		v = {8'd0, page_mem[s*PAGE + o]};
		if (half && o != 8'hFF) begin
			v[15:8] = page_mem[s*PAGE + o + 1];
		end
		return v;
	endfunction

	function automatic void predict(input opcode_t op, input logic [22:0] a,
			input logic [7:0] d);
		cache_result_t r;
		logic [14:0] t;
		logic [7:0] o;
		int hit;
		logic [3:0] s;
		t = a[22:8];
		o = a[7:0];
		r = '0;
		if (op == OP_FILL) begin
			if (!filling) begin
				r.kind = KIND_REJECT;
				expected_results.push_back(r);
				return;
			end
			page_mem[mru*PAGE + fill_idx] = d;
			fill_idx++;
			if (fill_idx < PAGE) begin
				return;
			end
			filling = 0;
			fill_idx = 0;
			r.kind = KIND_DATA;
			r.mem_address = {tag_of[mru], want_ofs};
			r.data_out = fetch_value(mru, want_ofs, want_half);
			r.slot = mru;
			expected_results.push_back(r);
			return;
		end
		if (filling) begin
			r.kind = KIND_REJECT;
			expected_results.push_back(r);
			return;
		end
		hit = -1;
		for (int i = 0; i < used; i++) begin
			if (hit < 0 && tag_of[i] == t) begin
				hit = i;
			end
		end
		if (op == OP_WR_BYTE) begin
			r.kind = KIND_WRITE;
			r.mem_address = a;
			r.data_out = {8'd0, d};
			if (hit >= 0) begin
				page_mem[hit*PAGE + o] = d;
				r.was_hit = 1'b1;
				r.slot = 4'(hit);
			end
			expected_results.push_back(r);
			return;
		end
		if (hit >= 0) begin
			s = 4'(hit);
			promote(s);
			r.kind = KIND_DATA;
			r.mem_address = a;
			r.data_out = fetch_value(s, o, op == OP_RD_HALF);
			r.was_hit = 1'b1;
			r.slot = s;
			expected_results.push_back(r);
			return;
		end
		if (used < SLOTS) begin
			s = 4'(used);
			older_of[s] = s;
			newer_of[s] = mru;
			older_of[mru] = s;
			mru = s;
			used++;
		end else begin
			s = lru;
			promote(s);
		end
		tag_of[s] = t;
		filling = 1;
		fill_idx = 0;
		want_ofs = o;
		want_half = (op == OP_RD_HALF);
		r.kind = KIND_FETCH;
		r.mem_address = {t, 8'd0};
		r.slot = s;
		expected_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cache_result_t got, want;
		if (!arst_n) begin
			used = 0;
			mru = 0;
			lru = 0;
			filling = 0;
			fill_idx = 0;
			mismatches = 0;
			expected_results.delete();
			for (int i = 0; i < SLOTS; i++) begin
				older_of[i] = 0;
				newer_of[i] = 0;
				tag_of[i] = 0;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{kind_t'(rsp.kind), rsp.mem_address, rsp.data_out, rsp.was_hit,
					rsp.slot};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result word %p", $time, got);
					end
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.mem_address !== want.mem_address
							|| got.data_out !== want.data_out || got.was_hit !== want.was_hit
							|| got.slot !== want.slot) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch, expected %p, actual %p", $time,
								want, got);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				predict(opcode_t'(req.opcode), req.address, req.data_in);
			end
		end
		mon.outstanding = expected_results.size();
		mon.failures = mismatches;
	end

endmodule

// ===== tb/lru_page_cache_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_controller_tb
// Drives request words into the page cache with random idling and a long
// receiver stall; the verdict needs no failures and no words outstanding.
// ----------------------------------------------------------------------------
module lru_page_cache_controller_tb;
	import lpc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	bit   calm = 0;
	bit   hold_off = 0;
	bit   held = 0;

	lpc_req_if #(.AW(23)) req ();
	lpc_rsp_if #(.AW(23), .SW(4)) rsp ();
	lpc_tb_if mon ();

	lru_page_cache_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lpc_checker i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mon    (mon)
	);

	always #5 clk = ~clk;

	logic [14:0] pages [24];
	int unsigned sent;

	task automatic send(input opcode_t op, input logic [22:0] a, input logic [7:0] d);
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.opcode <= op;
		req.address <= a;
		req.data_in <= d;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	task automatic fill_page(input bit random_data);
		for (int i = 0; i < 256; i++) begin
			send(OP_FILL, 23'($urandom), random_data ? 8'($urandom) : 8'(i ^ 8'h5A));
		end
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (mon.outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [22:0] pick_address();
		return {pages[$urandom_range(0, 23)], 8'($urandom)};
	endfunction

	initial begin
		rsp.ready = 0;
		repeat (3000) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rsp.ready <= 1;
		end
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int r;
		logic [22:0] a;
		req.valid = 0;
		req.opcode = OP_RD_BYTE;
		req.address = 0;
		req.data_in = 0;
		sent = 0;
		for (int i = 0; i < 24; i++) begin
			pages[i] = 15'($urandom);
		end
		pages[0] = 15'h7FFF;
		pages[1] = 15'h0000;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(OP_FILL, 0, 8'h00);
		send(OP_WR_BYTE, 23'h7FFFFF, 8'hFF);
		send(OP_RD_HALF, 23'h7FFFFF, 8'h00);
		send(OP_RD_BYTE, 23'h000000, 8'hFF);
		send(OP_WR_BYTE, 23'h7FFFFF, 8'h00);
		fill_page(0);
		send(OP_RD_BYTE, 23'h000010, 8'h00);
		send(OP_RD_HALF, 23'h000010, 8'h00);
		send(OP_RD_HALF, 23'h0000FF, 8'h00);
		send(OP_WR_BYTE, 23'h0000FF, 8'hA5);
		send(OP_WR_BYTE, 23'h000100, 8'hFF);
		send(OP_RD_HALF, 23'h7FFFFE, 8'h00);
		send(OP_RD_HALF, 23'h7FFFFF, 8'h00);
		send(OP_RD_BYTE, 23'h000000, 8'h00);
		send(OP_RD_BYTE, 23'h7FFF80, 8'h00);
		send(OP_FILL, 0, 8'hFF);
		drain();

		while (sent < 1000) begin
			r = $urandom_range(0, 9);
			a = pick_address();
			if (r < 4) begin
				send(opcode_t'($urandom_range(0, 1)), a, 8'($urandom));
				fill_page($urandom_range(0, 1));
			end else if (r < 7) begin
				send(OP_WR_BYTE, a, 8'($urandom));
			end else if (r < 9) begin
				send(opcode_t'($urandom_range(0, 1)), a, 8'($urandom));
			end else begin
				send(opcode_t'($urandom_range(0, 3)), 23'($urandom), 8'($urandom));
			end
			if (sent > 600 && !held) begin
				held = 1;
				hold_off = 1;
			end
		end
		drain();
		repeat (20) @(posedge clk);

		calm = 1;
		while (sent < 1850) begin
			r = $urandom_range(0, 9);
			a = pick_address();
			if (r < 2 && sent < 1590) begin
				send(opcode_t'($urandom_range(0, 1)), a, 8'($urandom));
				fill_page(1);
			end else if (r < 5) begin
				send(OP_WR_BYTE, a, 8'($urandom));
			end else begin
				send(opcode_t'($urandom_range(0, 1)), a, 8'($urandom));
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (mon.failures == 0 && mon.outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_req_if.sv
hw/rtl/lpc_rsp_if.sv
hw/rtl/lru_page_cache_controller.sv
tb/lpc_tb_pkg.sv
tb/lpc_tb_if.sv
tb/lpc_checker.sv
tb/lru_page_cache_controller_tb.sv
